>>> rtl/qam_soft_demapper_assert.svh
// Assertion macros for the soft demapper.
// Included by the top level; depends on nothing else.
`ifndef QAM_SOFT_DEMAPPER_ASSERT_SVH
`define QAM_SOFT_DEMAPPER_ASSERT_SVH
`ifndef SYNTHESIS
`define QSD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define QSD_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define QSD_ASSERT(lbl, clk, rstn, prop, msg)
`define QSD_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/qsd_pkg.sv
// Shared types and constants of the soft demapper.
// Used by qsd_lane and qam_soft_demapper; depends on nothing.
package qsd_pkg;

  typedef enum logic [1:0] {
    QSD_QPSK  = 2'd0,
    QSD_16QAM = 2'd1,
    QSD_64QAM = 2'd2,
    QSD_RSVD  = 2'd3
  } qsd_mod_t;

  typedef enum logic [2:0] {
    QSD_REG_MOD    = 3'd0,
    QSD_REG_SINGLE = 3'd1,
    QSD_REG_AGC_QP = 3'd2,
    QSD_REG_AGC_16 = 3'd3,
    QSD_REG_AGC_64 = 3'd4
  } qsd_reg_t;

  localparam logic signed [15:0] QSD_MUL_QPSK  = 16'shA582;
  localparam logic signed [15:0] QSD_MUL_16QAM = 16'shD786;
  localparam logic signed [15:0] QSD_MUL_64_S  = 16'shEC40;
  localparam logic signed [15:0] QSD_MUL_64_M  = 16'shB100;
  localparam logic signed [15:0] QSD_THR_16QAM = 16'sh199A;
  localparam logic signed [15:0] QSD_THR_64_A  = 16'sh0C31;
  localparam logic signed [15:0] QSD_THR_64_B  = 16'sh0618;

  localparam logic [3:0] QSD_BASE_SINGLE   = 4'd9;
  localparam logic [3:0] QSD_BASE_MULTI_64 = 4'd13;
  localparam logic [3:0] QSD_BASE_MULTI    = 4'd12;

  // Per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } qsd_en_t;

  // Output formatting: shift, extra right shift, keep mask for the three bits
  typedef struct packed {
    logic [3:0] shift;
    logic       extra;
    logic [2:0] keep;
  } qsd_fmt_t;

  typedef struct packed {
    qsd_fmt_t   fmt;
    logic [2:0] count;
    logic       last;
  } qsd_ctrl_t;

endpackage

>>> rtl/qam_soft_demapper.sv
// Max-log soft demapper for QPSK, 16QAM and 64QAM: top level, register port, pipeline control.
// Depends on qsd_pkg, qsd_lane and qam_soft_demapper_assert.svh.
//
// One symbol enters per clock while in_stall is low, and its soft bits leave through four
// register stages, one result per transaction. The stages are the mode multipliers, the first
// abs-minus-threshold step, the second one, then saturating shift and byte pick into the
// output register. An empty stage lets the stages behind it advance while the output is
// stalled, so in_stall rises only once all four stages hold a symbol. Registers must be
// written through the APB port only while the pipeline is empty, not enforced by the block.
`include "qam_soft_demapper_assert.svh"
module qam_soft_demapper import qsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_sym_upper,
  input  logic signed [15:0] in_sym_lower,
  input  logic signed [15:0] in_chan_weight,
  input  logic               in_last_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [7:0]  out_soft_b1,
  output logic signed [7:0]  out_soft_b2,
  output logic signed [7:0]  out_soft_b3,
  output logic signed [7:0]  out_soft_b4,
  output logic signed [7:0]  out_soft_b5,
  output logic signed [7:0]  out_soft_b6,
  output logic [2:0]         out_soft_count,
  output logic               out_last_out
);

  qsd_mod_t   mod_r;
  logic       single_r;
  logic [3:0] agc_qp_r, agc_16_r, agc_64_r;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r    <= QSD_QPSK;
      single_r <= 1'b1;
      agc_qp_r <= 4'd6;
      agc_16_r <= 4'd5;
      agc_64_r <= 4'd3;
    end else if (cfg_wr) begin
      case (qsd_reg_t'(paddr[4:2]))
        QSD_REG_MOD:    mod_r    <= qsd_mod_t'(pwdata[1:0]);
        QSD_REG_SINGLE: single_r <= pwdata[0];
        QSD_REG_AGC_QP: agc_qp_r <= pwdata[3:0];
        QSD_REG_AGC_16: agc_16_r <= pwdata[3:0];
        QSD_REG_AGC_64: agc_64_r <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (qsd_reg_t'(paddr[4:2]))
      QSD_REG_MOD:    prdata = {30'd0, mod_r};
      QSD_REG_SINGLE: prdata = {31'd0, single_r};
      QSD_REG_AGC_QP: prdata = {28'd0, agc_qp_r};
      QSD_REG_AGC_16: prdata = {28'd0, agc_16_r};
      QSD_REG_AGC_64: prdata = {28'd0, agc_64_r};
      default:        prdata = 32'd0;
    endcase
  end

  // Mode decode at entry
  logic signed [15:0] mul_k, thr_k, w_sel;
  logic [3:0]         base, agc;
  qsd_ctrl_t          ctrl0;

  always_comb begin
    mul_k       = 16'sd0;
    thr_k       = QSD_THR_64_A;
    w_sel       = in_chan_weight;
    base        = QSD_BASE_SINGLE;
    agc         = agc_qp_r;
    ctrl0.count = 3'd0;
    ctrl0.fmt.keep  = 3'b000;
    ctrl0.fmt.extra = 1'b0;
    case (mod_r)
      QSD_QPSK: begin
        mul_k = QSD_MUL_QPSK;
        base  = single_r ? QSD_BASE_SINGLE : QSD_BASE_MULTI;
        agc   = agc_qp_r;
        ctrl0.count    = 3'd2;
        ctrl0.fmt.keep = 3'b001;
      end
      QSD_16QAM: begin
        mul_k = QSD_MUL_16QAM;
        thr_k = QSD_THR_16QAM;
        w_sel = in_chan_weight >>> 2;
        base  = single_r ? QSD_BASE_SINGLE : QSD_BASE_MULTI;
        agc   = agc_16_r;
        ctrl0.count    = 3'd4;
        ctrl0.fmt.keep = 3'b011;
      end
      QSD_64QAM: begin
        mul_k = single_r ? QSD_MUL_64_S : QSD_MUL_64_M;
        base  = single_r ? QSD_BASE_SINGLE : QSD_BASE_MULTI_64;
        agc   = agc_64_r;
        ctrl0.count     = 3'd6;
        ctrl0.fmt.keep  = 3'b111;
        ctrl0.fmt.extra = !single_r;
      end
      default: ;
    endcase
    ctrl0.fmt.shift = (agc > base) ? 4'd0 : 4'(base - agc);
    ctrl0.last      = in_last_in;
  end

  // Pipeline control: a stage loads when it is empty or the next one loads
  logic      v1_r, v2_r, v3_r, v4_r;
  qsd_en_t   en;
  qsd_ctrl_t ctrl1_r, ctrl2_r, ctrl3_r, ctrl4_r;
  logic signed [31:0] thr_a1_r, thr_b1_r, thr_b2_r;

  assign en.s4    = !v4_r || !out_stall;
  assign en.s3    = !v3_r || en.s4;
  assign en.s2    = !v2_r || en.s3;
  assign en.s1    = !v1_r || en.s2;
  assign in_stall = !en.s1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en.s4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ctrl1_r  <= ctrl0;
      thr_a1_r <= 32'(w_sel * thr_k);
      thr_b1_r <= 32'(in_chan_weight * QSD_THR_64_B);
    end
    if (en.s2) begin
      ctrl2_r  <= ctrl1_r;
      thr_b2_r <= thr_b1_r;
    end
    if (en.s3) ctrl3_r <= ctrl2_r;
    if (en.s4) ctrl4_r <= ctrl3_r;
  end

  qsd_lane u_lane_up (
    .clk    (clk),
    .en     (en),
    .in_sym (in_sym_upper),
    .mul_k  (mul_k),
    .thr_a  (thr_a1_r),
    .thr_b  (thr_b2_r),
    .fmt    (ctrl3_r.fmt),
    .soft_a (out_soft_b1),
    .soft_b (out_soft_b3),
    .soft_c (out_soft_b5)
  );

  qsd_lane u_lane_lo (
    .clk    (clk),
    .en     (en),
    .in_sym (in_sym_lower),
    .mul_k  (mul_k),
    .thr_a  (thr_a1_r),
    .thr_b  (thr_b2_r),
    .fmt    (ctrl3_r.fmt),
    .soft_a (out_soft_b2),
    .soft_b (out_soft_b4),
    .soft_c (out_soft_b6)
  );

  assign out_valid      = v4_r;
  assign out_soft_count = ctrl4_r.count;
  assign out_last_out   = ctrl4_r.last;

  `QSD_ASSERT(a_accept_fills, clk, rst_n, in_valid && !in_stall |=> v1_r, "accepted symbol lost at stage one")
  `QSD_ASSERT(a_stall_full, clk, rst_n, in_stall |-> (v1_r && v2_r && v3_r && v4_r), "input stalled with an empty stage")
  `QSD_ASSERT(a_count_code, clk, rst_n, out_valid |-> (out_soft_count == 3'd0 || out_soft_count == 3'd2 || out_soft_count == 3'd4 || out_soft_count == 3'd6), "bad soft bit count")
  `QSD_ASSERT_NR(a_qpsk_zero, clk, (out_valid && out_soft_count == 3'd2) |-> (out_soft_b3 == 8'sd0 && out_soft_b4 == 8'sd0 && out_soft_b5 == 8'sd0 && out_soft_b6 == 8'sd0), "unused QPSK soft bits not zero")

endmodule

>>> rtl/qsd_lane.sv
// Datapath of one symbol half: product, two threshold stages and formatting.
// Depends on qsd_pkg; stage enables and side values come from the top level.
module qsd_lane import qsd_pkg::*; (
  input  logic               clk,
  input  qsd_en_t            en,
  input  logic signed [15:0] in_sym,
  input  logic signed [15:0] mul_k,
  input  logic signed [31:0] thr_a,
  input  logic signed [31:0] thr_b,
  input  qsd_fmt_t           fmt,
  output logic signed [7:0]  soft_a,
  output logic signed [7:0]  soft_b,
  output logic signed [7:0]  soft_c
);

  logic signed [31:0] p1_r, p2_r, p3_r;
  logic signed [31:0] q2_r, q3_r;
  logic signed [31:0] r3_r;
  logic signed [31:0] q2_nxt, r3_nxt;
  logic signed [7:0]  soft_a_r, soft_b_r, soft_c_r;

  function automatic logic signed [31:0] abs_sub(input logic signed [31:0] v,
                                                 input logic signed [31:0] t);
    logic [31:0] a;
    a = v[31] ? (v == 32'sh80000000 ? 32'h7FFFFFFF : 32'(-v)) : v;
    return $signed(a - t);
  endfunction

  function automatic logic signed [7:0] fmt_soft(input logic signed [31:0] v,
                                                 input logic [3:0] s,
                                                 input logic ex,
                                                 input logic keep);
    logic signed [45:0] wide;
    logic signed [31:0] r;
    wide = {{14{v[31]}}, v} << s;
    if (!(&wide[45:31]) && (|wide[45:31])) begin
      r = wide[45] ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else begin
      r = wide[31:0];
    end
    if (ex) begin
      r = r >>> 2;
    end
    return keep ? r[31:24] : 8'sd0;
  endfunction

  assign q2_nxt = abs_sub(p1_r, thr_a);
  assign r3_nxt = abs_sub(q2_r, thr_b);

  always_ff @(posedge clk) begin
    if (en.s1) begin
      p1_r <= 32'(in_sym * mul_k);
    end
    if (en.s2) begin
      p2_r <= p1_r;
      q2_r <= q2_nxt;
    end
    if (en.s3) begin
      p3_r <= p2_r;
      q3_r <= q2_r;
      r3_r <= r3_nxt;
    end
    if (en.s4) begin
      soft_a_r <= fmt_soft(p3_r, fmt.shift, fmt.extra, fmt.keep[0]);
      soft_b_r <= fmt_soft(q3_r, fmt.shift, fmt.extra, fmt.keep[1]);
      soft_c_r <= fmt_soft(r3_r, fmt.shift, fmt.extra, fmt.keep[2]);
    end
  end

  assign soft_a = soft_a_r;
  assign soft_b = soft_b_r;
  assign soft_c = soft_c_r;

endmodule

>>> dv/qam_soft_demapper_checker.sv
// Checker for the soft demapper: tracks the register port, predicts every soft-bit word
// and compares it with what leaves the block. Depends on qsd_pkg only.
module qam_soft_demapper_checker import qsd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic [31:0]        prdata,
  input  logic               pready,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_sym_upper,
  input  logic signed [15:0] in_sym_lower,
  input  logic signed [15:0] in_chan_weight,
  input  logic               in_last_in,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [7:0]  out_soft_b1,
  input  logic signed [7:0]  out_soft_b2,
  input  logic signed [7:0]  out_soft_b3,
  input  logic signed [7:0]  out_soft_b4,
  input  logic signed [7:0]  out_soft_b5,
  input  logic signed [7:0]  out_soft_b6,
  input  logic [2:0]         out_soft_count,
  input  logic               out_last_out,
  output int                 mismatches,
  output int                 pending,
  output int                 checked
);

  localparam longint MUL_QPSK   = -23166;
  localparam longint MUL_16QAM  = -10362;
  localparam longint MUL_64_ONE = -5056;
  localparam longint MUL_64_MANY = -20224;
  localparam longint THR_16QAM  = 6554;
  localparam longint THR_64_NEAR = 3121;
  localparam longint THR_64_FAR  = 1560;
  localparam int     BASE_ONE    = 9;
  localparam int     BASE_MANY   = 12;
  localparam int     BASE_MANY_64 = 13;
  localparam int     REPORT_LIMIT = 20;

  typedef struct packed {
    logic [5:0][7:0] llr;
    logic [2:0]      count;
    logic            last;
  } soft_word_t;

  qsd_mod_t   mod_r;
  logic       single_r;
  logic [3:0] agc_qpsk_r, agc_16_r, agc_64_r;

  soft_word_t soft_q[$];
  int         fail_count = 0;
  int         n_checked = 0;

  function automatic longint wrap_to_int(longint v);
    int t;
    t = int'(v[31:0]);
    return t;
  endfunction

  function automatic longint abs_sat(longint v);
    longint a;
    a = (v < 0) ? -v : v;
    return (a > 64'sd2147483647) ? 64'sd2147483647 : a;
  endfunction

  // Saturating left shift to 32 bits, optional extra >> 2, then keep bits 31:24
  function automatic logic [7:0] to_byte(longint v, int sh, bit extra);
    longint r;
    r = v * (longint'(1) << sh);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    if (extra) r = r >>> 2;
    r = r >>> 24;
    return r[7:0];
  endfunction

  function automatic soft_word_t demap_symbol(logic signed [15:0] up, logic signed [15:0] lo,
                                              logic signed [15:0] w, logic last);
    longint     prod[6];
    longint     mul, thr_near, thr_far;
    int         base, agc, sh, nbits;
    bit         extra;
    soft_word_t r;
    for (int k = 0; k < 6; k++) prod[k] = 0;
    r = '0;
    base = 0;
    agc = 0;
    nbits = 0;
    extra = 1'b0;
    case (mod_r)
      QSD_QPSK: begin
        prod[0] = longint'(up) * MUL_QPSK;
        prod[1] = longint'(lo) * MUL_QPSK;
        base = single_r ? BASE_ONE : BASE_MANY;
        agc = agc_qpsk_r;
        nbits = 2;
      end
      QSD_16QAM: begin
        thr_near = (longint'(w) >>> 2) * THR_16QAM;
        prod[0] = longint'(up) * MUL_16QAM;
        prod[1] = longint'(lo) * MUL_16QAM;
        prod[2] = wrap_to_int(abs_sat(prod[0]) - thr_near);
        prod[3] = wrap_to_int(abs_sat(prod[1]) - thr_near);
        base = single_r ? BASE_ONE : BASE_MANY;
        agc = agc_16_r;
        nbits = 4;
      end
      QSD_64QAM: begin
        mul = single_r ? MUL_64_ONE : MUL_64_MANY;
        thr_near = longint'(w) * THR_64_NEAR;
        thr_far = longint'(w) * THR_64_FAR;
        prod[0] = longint'(up) * mul;
        prod[1] = longint'(lo) * mul;
        prod[2] = wrap_to_int(abs_sat(prod[0]) - thr_near);
        prod[3] = wrap_to_int(abs_sat(prod[1]) - thr_near);
        prod[4] = wrap_to_int(abs_sat(prod[2]) - thr_far);
        prod[5] = wrap_to_int(abs_sat(prod[3]) - thr_far);
        base = single_r ? BASE_ONE : BASE_MANY_64;
        agc = agc_64_r;
        extra = !single_r;
        nbits = 6;
      end
      default: ;
    endcase
    // an AGC shift beyond the base leaves the value unshifted
    sh = (agc > base) ? 0 : base - agc;
    for (int k = 0; k < nbits; k++) r.llr[k] = to_byte(prod[k], sh, extra);
    r.count = nbits[2:0];
    r.last = last;
    return r;
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (qsd_reg_t'(idx))
      QSD_REG_MOD:    return 32'(mod_r);
      QSD_REG_SINGLE: return 32'(single_r);
      QSD_REG_AGC_QP: return 32'(agc_qpsk_r);
      QSD_REG_AGC_16: return 32'(agc_16_r);
      QSD_REG_AGC_64: return 32'(agc_64_r);
      default:        return 32'd0;
    endcase
  endfunction

  task automatic check_field(string what, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what,
                 $signed(want), $signed(got));
    end
  endtask

  always @(posedge clk) begin : watch
    soft_word_t want, got;
    if (!rst_n) begin
      mod_r <= QSD_QPSK;
      single_r <= 1'b1;
      agc_qpsk_r <= 4'd6;
      agc_16_r <= 4'd5;
      agc_64_r <= 4'd3;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (qsd_reg_t'(paddr[4:2]))
            QSD_REG_MOD:    mod_r <= qsd_mod_t'(pwdata[1:0]);
            QSD_REG_SINGLE: single_r <= pwdata[0];
            QSD_REG_AGC_QP: agc_qpsk_r <= pwdata[3:0];
            QSD_REG_AGC_16: agc_16_r <= pwdata[3:0];
            QSD_REG_AGC_64: agc_64_r <= pwdata[3:0];
            default: ;
          endcase
        end else if (prdata !== reg_value(paddr[4:2])) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: register %0d readback mismatch, expected %0h, got %0h", $time,
                     paddr[4:2], reg_value(paddr[4:2]), prdata);
        end
      end
      if (in_valid && !in_stall)
        soft_q.push_back(demap_symbol(in_sym_upper, in_sym_lower, in_chan_weight, in_last_in));
      if (out_valid && !out_stall) begin
        got.llr = {out_soft_b6, out_soft_b5, out_soft_b4, out_soft_b3, out_soft_b2,
                   out_soft_b1};
        got.count = out_soft_count;
        got.last = out_last_out;
        if (soft_q.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT)
            $display("%0t: result with nothing expected, expected none, got %0h", $time, got);
        end else begin
          want = soft_q.pop_front();
          for (int k = 0; k < 6; k++)
            check_field($sformatf("soft_b%0d", k + 1), want.llr[k], got.llr[k]);
          check_field("soft_count", 8'(want.count), 8'(got.count));
          check_field("last_out", 8'(want.last), 8'(got.last));
          n_checked++;
        end
      end
    end
    mismatches <= fail_count;
    pending <= soft_q.size();
    checked <= n_checked;
  end

endmodule

>>> dv/qam_soft_demapper_tb.sv
// Top of the soft demapper testbench: clock, reset, register setup, symbol stimulus and verdict.
// Depends on qsd_pkg, qam_soft_demapper and qam_soft_demapper_checker.
module qam_soft_demapper_tb;
  import qsd_pkg::*;

  localparam int N_ITEMS = 1900;
  localparam int QUIET_LIMIT = 1000;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               psel, penable, pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata, prdata;
  logic               pready;
  logic               in_valid, in_stall;
  logic signed [15:0] in_sym_upper, in_sym_lower, in_chan_weight;
  logic               in_last_in;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [7:0]  out_soft_b1, out_soft_b2, out_soft_b3;
  logic signed [7:0]  out_soft_b4, out_soft_b5, out_soft_b6;
  logic [2:0]         out_soft_count;
  logic               out_last_out;

  int mismatches, pending, checked;
  int gap_pct = 0;
  int stall_pct = 0;
  int stall_left = 0;
  int quiet = 0;
  int sent = 0;
  int settings = 0;

  qam_soft_demapper uut (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_sym_upper(in_sym_upper),
    .in_sym_lower(in_sym_lower), .in_chan_weight(in_chan_weight), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_soft_b1(out_soft_b1), .out_soft_b2(out_soft_b2), .out_soft_b3(out_soft_b3),
    .out_soft_b4(out_soft_b4), .out_soft_b5(out_soft_b5), .out_soft_b6(out_soft_b6),
    .out_soft_count(out_soft_count), .out_last_out(out_last_out)
  );

  qam_soft_demapper_checker soft_chk (
    .clk(clk), .rst_n(rst_n),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .in_sym_upper(in_sym_upper),
    .in_sym_lower(in_sym_lower), .in_chan_weight(in_chan_weight), .in_last_in(in_last_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_soft_b1(out_soft_b1), .out_soft_b2(out_soft_b2), .out_soft_b3(out_soft_b3),
    .out_soft_b4(out_soft_b4), .out_soft_b5(out_soft_b5), .out_soft_b6(out_soft_b6),
    .out_soft_count(out_soft_count), .out_last_out(out_last_out),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Mostly short idles, now and then a long one
  function automatic int idle_len(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 10;
      2:       return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    logic signed [15:0] v;
    case ($urandom_range(0, 7))
      0:       v = 16'sh8000;
      1:       v = 16'sh7fff;
      2:       v = 16'($urandom_range(0, 255)) - 16'sd128;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  function automatic logic [3:0] pick_agc();
    case ($urandom_range(0, 5))
      0:       return 4'd0;
      1:       return 4'd9;
      default: return 4'($urandom_range(0, 9));
    endcase
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rst_n && $urandom_range(0, 99) < stall_pct) begin
      out_stall <= 1'b1;
      stall_left <= idle_len(100) - 1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: end the run after too long without any transaction
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic apb_xfer(input qsd_reg_t idx, input logic wr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic read_all();
    for (int i = 0; i <= int'(QSD_REG_AGC_64); i++) apb_xfer(qsd_reg_t'(i), 1'b0, 32'd0);
  endtask

  // Hold off until the pipeline has handed out every expected word
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_regs(input qsd_mod_t m, input logic one_port, input logic [3:0] agc_qp,
                          input logic [3:0] agc_16, input logic [3:0] agc_64);
    wait_drained();
    apb_xfer(QSD_REG_MOD, 1'b1, 32'(m));
    apb_xfer(QSD_REG_SINGLE, 1'b1, 32'(one_port));
    apb_xfer(QSD_REG_AGC_QP, 1'b1, 32'(agc_qp));
    apb_xfer(QSD_REG_AGC_16, 1'b1, 32'(agc_16));
    apb_xfer(QSD_REG_AGC_64, 1'b1, 32'(agc_64));
    read_all();
    settings++;
  endtask

  task automatic send_symbol(input logic [15:0] up, input logic [15:0] lo,
                             input logic [15:0] w, input logic last);
    int gap;
    gap = idle_len(gap_pct);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sym_upper <= up;
    in_sym_lower <= lo;
    in_chan_weight <= w;
    in_last_in <= last;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Full-scale and near-zero corners of all three input halves
  task automatic send_corners(input int n);
    logic [15:0] ups[4], los[4], ws[4];
    logic        lasts[4];
    ups = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff};
    los = '{16'h7fff, 16'h8000, 16'hffff, 16'h0000};
    ws = '{16'h7fff, 16'h8000, 16'h0001, 16'h8000};
    lasts = '{1'b1, 1'b0, 1'b0, 1'b1};
    for (int i = 0; i < n; i++) send_symbol(ups[i], los[i], ws[i], lasts[i]);
  endtask

  initial begin
    int n;
    qsd_mod_t m;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_sym_upper = '0;
    in_sym_lower = '0;
    in_chan_weight = '0;
    in_last_in = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    read_all();
    gap_pct = 20;
    stall_pct = 20;
    send_corners(4);
    set_regs(QSD_16QAM, 1'b1, 4'd6, 4'd5, 4'd3);
    send_corners(4);
    set_regs(QSD_64QAM, 1'b1, 4'd0, 4'd9, 4'd0);
    send_corners(4);
    set_regs(QSD_64QAM, 1'b0, 4'd9, 4'd0, 4'd9);
    send_corners(3);
    set_regs(QSD_16QAM, 1'b0, 4'd0, 4'd0, 4'd0);
    send_corners(2);
    set_regs(QSD_RSVD, 1'b1, 4'd9, 4'd9, 4'd9);
    send_corners(2);
    // AGC beyond the base shift: clamp to no shift
    set_regs(QSD_QPSK, 1'b1, 4'hf, 4'hf, 4'hf);
    send_corners(2);

    while (sent < N_ITEMS) begin
      m = ($urandom_range(0, 9) == 0) ? QSD_RSVD : qsd_mod_t'(2'($urandom_range(0, 2)));
      set_regs(m, 1'($urandom_range(0, 1)), pick_agc(), pick_agc(), pick_agc());
      gap_pct = pick_pct();
      stall_pct = pick_pct();
      n = $urandom_range(40, 200);
      repeat (n) send_symbol(pick_half(), pick_half(), pick_half(), $urandom_range(0, 15) == 0);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    $display("Covered %0d symbols over %0d register settings: all modulations, both port modes,",
             sent, settings);
    $display("AGC shifts 0 to 9 plus clamped; %0d words compared, %0d mismatches.", checked,
             mismatches);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
